### rtl/ce_pkg.sv
// ce_pkg: shared types, constants and the log table builder for the
// cross-entropy gradient block. no dependencies.
package ce_pkg;

    localparam int FRAC_BITS = 24;
    localparam int TAB_BITS  = 8;
    localparam int TAB_DEPTH = 1 << TAB_BITS;
    localparam int LN_SHIFT  = 32 - FRAC_BITS;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [47:0] SCALE_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] SCALE_ONE = 48'd1 << FRAC_BITS;

    typedef enum logic [1:0] {
        REG_DELTA_SCALE    = 2'd0,
        REG_OUTPUT_SCALING = 2'd1,
        REG_LOG_EPSILON    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] prob;
        logic [24:0] expected_value;
        logic        last_in;
    } req_t;

    typedef struct packed {
        logic signed [47:0] delta;
        logic signed [31:0] loss_term;
        logic               last_out;
    } rsp_t;

    typedef struct packed {
        logic [31:0]        output_scaling;
        logic [24:0]        log_epsilon;
        logic [47:0]        combined_scale;
        logic signed [31:0] log_scaling;
    } cfg_t;

    // ln(1 + i/TAB_DEPTH) in Q0.32, evaluated at elaboration only
    function automatic logic [31:0] ln_entry(input int i);
        logic [63:0] z;
        logic [63:0] l2;
        logic [63:0] p;
        int          k;
        l2 = '0;
        if (i == TAB_DEPTH) begin
            l2 = 64'd1 << 32;
        end
        else begin
            z = (64'd1 << 30) + ((64'(i) << 30) / TAB_DEPTH);
            for (k = 31; k >= 0; k--) begin
                z = (z * z) >> 30;
                if (z >= (64'd1 << 31)) begin
                    z = z >> 1;
                    l2 = l2 | (64'd1 << k);
                end
            end
        end
        p = (l2 * 64'(LN2_Q32) + (64'd1 << 31)) >> 32;
        return p[31:0];
    endfunction

endpackage

### rtl/cross_entropy_loss_gradient.sv
// cross_entropy_loss_gradient: top level, apb config registers and wiring.
// depends on ce_pkg, ce_derive, ce_dp.
//
// usage
//   request channel req_valid/req_ready/req_data carries one element:
//   scaled probability, expected value and an end-of-vector flag.
//   result channel rsp_valid/rsp_ready/rsp_data returns the saturated
//   delta, the loss term and the flag, one result per request, in order.
//   config registers sit on an apb port: delta_scale at 0x0,
//   output_scaling at 0x4, log_epsilon at 0x8; pready is always high.
// timing
//   one request per cycle sustained while no scale update is running and
//   results are taken, set by the eight-stage element pipeline.
//   a write to delta_scale or output_scaling starts a 56-step bit-serial
//   divide plus a pass through the log pipeline; req_ready stays low
//   until the scale and log of scaling are updated (no divide when
//   output_scaling is zero).
// reset
//   registers return to 1.0, 1.0 and 2 lsb; combined scale 1.0, log 0.
// stall
//   each stage holds while the one after it is full and stalled, so a
//   bubble is filled and nothing is lost or repeated.
module cross_entropy_loss_gradient (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          req_valid,
    output logic          req_ready,
    input  ce_pkg::req_t  req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ce_pkg::rsp_t  rsp_data
);

    logic [31:0] ds_reg;
    logic [31:0] os_reg;
    logic [24:0] eps_reg;

    logic             wr;
    ce_pkg::reg_idx_t idx;
    logic             derive_start;
    logic             busy;
    ce_pkg::cfg_t     cfg;

    assign wr     = psel && penable && pwrite;
    assign idx    = ce_pkg::reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;

    // scale and log only depend on the first two registers
    assign derive_start = wr && (idx == ce_pkg::REG_DELTA_SCALE ||
                                 idx == ce_pkg::REG_OUTPUT_SCALING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ds_reg  <= 32'd1 << ce_pkg::FRAC_BITS;
            os_reg  <= 32'd1 << ce_pkg::FRAC_BITS;
            eps_reg <= 25'd2;
        end
        else if (wr)
        begin
            unique case (idx)
                ce_pkg::REG_DELTA_SCALE:    ds_reg  <= pwdata;
                ce_pkg::REG_OUTPUT_SCALING: os_reg  <= pwdata;
                ce_pkg::REG_LOG_EPSILON:    eps_reg <= pwdata[24:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            ce_pkg::REG_DELTA_SCALE:    prdata = ds_reg;
            ce_pkg::REG_OUTPUT_SCALING: prdata = os_reg;
            ce_pkg::REG_LOG_EPSILON:    prdata = 32'(eps_reg);
            default:                    prdata = '0;
        endcase
    end

    ce_derive u_derive (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (derive_start),
        .delta_scale    (ds_reg),
        .output_scaling (os_reg),
        .combined_scale (cfg.combined_scale),
        .log_scaling    (cfg.log_scaling),
        .busy           (busy)
    );

    assign cfg.output_scaling = os_reg;
    assign cfg.log_epsilon    = eps_reg;

    ce_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .hold      (busy),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

### rtl/ce_ln.sv
// ce_ln: four-stage pipelined natural log, table lookup with linear
// interpolation. depends on ce_pkg.
module ce_ln (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [32:0]        x,
    input  logic               x_valid,
    input  logic [3:0]         adv,
    output logic signed [31:0] lnp,
    output logic               lnp_valid,
    output logic               pend
);

    localparam logic signed [39:0] RND = 40'sd1 <<< (ce_pkg::LN_SHIFT - 1);

    logic [31:0] tab [0:ce_pkg::TAB_DEPTH];

    for (genvar g = 0; g <= ce_pkg::TAB_DEPTH; g++) begin : g_tab
        localparam logic [31:0] ENT = ce_pkg::ln_entry(g);
        assign tab[g] = ENT;
    end

    logic [3:0] vld_reg;

    // stage 1: leading one and normalize
    logic [5:0]  msb_c;
    logic [64:0] norm_c;
    logic [5:0]  msb1_reg;
    logic [31:0] frac1_reg;
    logic        zero1_reg;

    always_comb
    begin
        msb_c = '0;
        for (int i = 1; i < 33; i++)
        begin
            if (x[i])
            begin
                msb_c = 6'(i);
            end
        end
        norm_c = 65'(x) << (6'd32 - msb_c);
    end

    // stage 2: table read
    logic [ce_pkg::TAB_BITS-1:0] idx_c;
    logic [ce_pkg::TAB_BITS:0]   idx_n_c;
    logic [31:0] a2_reg;
    logic [31:0] da2_reg;
    logic [31:0] rem2_reg;
    logic [5:0]  msb2_reg;
    logic        zero2_reg;

    assign idx_c   = frac1_reg[31 -: ce_pkg::TAB_BITS];
    assign idx_n_c = {1'b0, idx_c} + 1'b1;

    // stage 3: interpolation product
    logic [63:0] m_c;
    logic [31:0] a3_reg;
    logic [31:0] mhi3_reg;
    logic [5:0]  msb3_reg;
    logic        zero3_reg;

    assign m_c = 64'(da2_reg) * 64'(rem2_reg);

    // stage 4: exponent term, round
    logic signed [6:0]  sm_c;
    logic signed [39:0] v_c;
    logic signed [39:0] r_c;
    logic signed [39:0] rs_c;
    logic signed [31:0] ln_reg;

    always_comb
    begin
        sm_c = $signed({1'b0, msb3_reg}) - 7'sd24;
        v_c  = 40'(sm_c) * $signed({8'd0, ce_pkg::LN2_Q32})
             + $signed({8'd0, a3_reg}) + $signed({8'd0, mhi3_reg});
        r_c  = v_c + RND;
        rs_c = r_c >>> ce_pkg::LN_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0]) vld_reg[0] <= x_valid;
            if (adv[1]) vld_reg[1] <= vld_reg[0];
            if (adv[2]) vld_reg[2] <= vld_reg[1];
            if (adv[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            msb1_reg  <= msb_c;
            frac1_reg <= norm_c[31:0];
            zero1_reg <= (x == '0);
        end
        if (adv[1])
        begin
            a2_reg    <= tab[idx_c];
            da2_reg   <= tab[idx_n_c] - tab[idx_c];
            rem2_reg  <= {frac1_reg[31-ce_pkg::TAB_BITS:0], ce_pkg::TAB_BITS'(0)};
            msb2_reg  <= msb1_reg;
            zero2_reg <= zero1_reg;
        end
        if (adv[2])
        begin
            a3_reg    <= a2_reg;
            mhi3_reg  <= m_c[63:32];
            msb3_reg  <= msb2_reg;
            zero3_reg <= zero2_reg;
        end
        if (adv[3])
        begin
            ln_reg <= zero3_reg ? 32'sh8000_0000 : 32'(rs_c);
        end
    end

    assign lnp       = ln_reg;
    assign lnp_valid = vld_reg[3];
    assign pend      = |vld_reg;

endmodule

### rtl/ce_derive.sv
// ce_derive: recomputes combined scale (bit-serial divider) and the log of
// the output scaling after a config write. depends on ce_pkg, ce_ln.
module ce_derive (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        delta_scale,
    input  logic [31:0]        output_scaling,
    output logic [47:0]        combined_scale,
    output logic signed [31:0] log_scaling,
    output logic               busy
);

    localparam int DW = 32 + ce_pkg::FRAC_BITS;

    logic              start_reg;
    logic              run_reg;
    logic [5:0]        cnt_reg;
    logic [32:0]       rem_reg;
    logic [DW-1:0]     dq_reg;
    logic [47:0]       cs_reg;
    logic signed [31:0] ls_reg;

    logic [32:0]   rsh_c;
    logic          ge_c;
    logic [32:0]   rem_next;
    logic [DW-1:0] dq_next;

    logic signed [31:0] ln_c;
    logic               ln_vld_c;
    logic               ln_pend_c;

    always_comb
    begin
        rsh_c    = {rem_reg[31:0], dq_reg[DW-1]};
        ge_c     = rsh_c >= {1'b0, output_scaling};
        rem_next = ge_c ? rsh_c - {1'b0, output_scaling} : rsh_c;
        dq_next  = {dq_reg[DW-2:0], ge_c};
    end

    ce_ln u_ln (
        .clk       (clk),
        .rst_n     (rst_n),
        .x         ({1'b0, output_scaling}),
        .x_valid   (start_reg),
        .adv       ('1),
        .lnp       (ln_c),
        .lnp_valid (ln_vld_c),
        .pend      (ln_pend_c)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b0;
            run_reg   <= 1'b0;
            cnt_reg   <= '0;
            cs_reg    <= ce_pkg::SCALE_ONE;
            ls_reg    <= '0;
        end
        else
        begin
            start_reg <= start;
            if (start_reg)
            begin
                if (output_scaling == '0)
                begin
                    // a divide still running from an earlier write is dropped
                    run_reg <= 1'b0;
                    cs_reg  <= ce_pkg::SCALE_MAX;
                end
                else
                begin
                    run_reg <= 1'b1;
                    cnt_reg <= 6'(DW - 1);
                end
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg <= 1'b0;
                    cs_reg  <= (dq_next[DW-1:48] != '0) ? ce_pkg::SCALE_MAX
                                                        : dq_next[47:0];
                end
            end
            if (ln_vld_c)
            begin
                ls_reg <= ln_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_reg)
        begin
            rem_reg <= '0;
            dq_reg  <= {delta_scale, ce_pkg::FRAC_BITS'(0)};
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dq_reg  <= dq_next;
        end
    end

    assign combined_scale = cs_reg;
    assign log_scaling    = ls_reg;
    assign busy           = start_reg || run_reg || ln_pend_c;

endmodule

### rtl/ce_dp.sv
// ce_dp: eight-stage element pipeline for delta and loss term.
// depends on ce_pkg, ce_ln.
module ce_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  ce_pkg::cfg_t  cfg,
    input  logic          hold,
    input  logic          req_valid,
    output logic          req_ready,
    input  ce_pkg::req_t  req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ce_pkg::rsp_t  rsp_data
);

    localparam int NS = 8;
    localparam logic [82:0] HALF_D = 83'd1 << (ce_pkg::FRAC_BITS - 1);
    localparam logic signed [59:0] HALF_L = 60'sd1 <<< (ce_pkg::FRAC_BITS - 1);

    logic [NS-1:0] v_reg;
    logic [NS-1:0] en;

    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || rsp_ready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign req_ready = en[0] && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0]) v_reg[0] <= req_valid && req_ready;
            for (int k = 1; k < NS; k++)
            begin
                if (en[k]) v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // stage 1
    logic [32:0] x1_reg;
    logic [56:0] ep1_reg;
    logic [31:0] p1_reg;
    logic [24:0] e1_reg;
    logic        l1_reg;
    // stage 2
    logic [57:0] t_sum_c;
    logic [34:0] diff_c;
    logic [33:0] mag2_reg;
    logic        neg2_reg;
    logic [24:0] e2_reg;
    logic        l2_reg;
    // stage 3
    logic [57:0] pplo3_reg;
    logic [57:0] pphi3_reg;
    logic        neg3_reg;
    logic [24:0] e3_reg;
    logic        l3_reg;
    // stage 4
    logic [82:0] prod_c;
    logic [58:0] q_c;
    logic [47:0] lim_c;
    logic [47:0] qs_c;
    logic [47:0] delta4_reg;
    logic [24:0] e4_reg;
    logic        l4_reg;
    // stage 5
    logic signed [31:0] lnp5_c;
    logic [47:0] delta5_reg;
    logic [24:0] e5_reg;
    logic        l5_reg;
    // stage 6
    logic signed [32:0] d6_reg;
    logic [47:0] delta6_reg;
    logic [24:0] e6_reg;
    logic        l6_reg;
    // stage 7
    logic signed [58:0] pr7_reg;
    logic [47:0] delta7_reg;
    logic        l7_reg;
    // stage 8
    logic signed [59:0] n_c;
    logic signed [59:0] sh_c;
    logic signed [31:0] loss_c;
    ce_pkg::rsp_t rsp_reg;

    always_comb
    begin
        t_sum_c = 58'(ep1_reg) + 58'(HALF_D);
        diff_c  = {3'b0, p1_reg} - {1'b0, t_sum_c[57:24]};

        prod_c = (83'(pphi3_reg) << 24) + 83'(pplo3_reg) + HALF_D;
        q_c    = prod_c[82:24];
        lim_c  = neg3_reg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        qs_c   = (q_c > 59'(lim_c)) ? lim_c : q_c[47:0];

        n_c  = -60'(pr7_reg);
        sh_c = (n_c + HALF_L) >>> ce_pkg::FRAC_BITS;
        if (sh_c > 60'sd2147483647)
        begin
            loss_c = 32'sh7FFF_FFFF;
        end
        else if (sh_c < -60'sd2147483648)
        begin
            loss_c = 32'sh8000_0000;
        end
        else
        begin
            loss_c = 32'(sh_c);
        end
    end

    ce_ln u_ln (
        .clk       (clk),
        .rst_n     (rst_n),
        .x         (x1_reg),
        .x_valid   (v_reg[0]),
        .adv       (en[4:1]),
        .lnp       (lnp5_c),
        .lnp_valid (),
        .pend      ()
    );

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg  <= {1'b0, req_data.prob} + 33'(cfg.log_epsilon);
            ep1_reg <= 57'(req_data.expected_value) * 57'(cfg.output_scaling);
            p1_reg  <= req_data.prob;
            e1_reg  <= req_data.expected_value;
            l1_reg  <= req_data.last_in;
        end
        if (en[1])
        begin
            neg2_reg <= diff_c[34];
            mag2_reg <= diff_c[34] ? 34'(-diff_c) : diff_c[33:0];
            e2_reg   <= e1_reg;
            l2_reg   <= l1_reg;
        end
        if (en[2])
        begin
            pplo3_reg <= 58'(mag2_reg) * 58'(cfg.combined_scale[23:0]);
            pphi3_reg <= 58'(mag2_reg) * 58'(cfg.combined_scale[47:24]);
            neg3_reg  <= neg2_reg;
            e3_reg    <= e2_reg;
            l3_reg    <= l2_reg;
        end
        if (en[3])
        begin
            delta4_reg <= neg3_reg ? -qs_c : qs_c;
            e4_reg     <= e3_reg;
            l4_reg     <= l3_reg;
        end
        if (en[4])
        begin
            delta5_reg <= delta4_reg;
            e5_reg     <= e4_reg;
            l5_reg     <= l4_reg;
        end
        if (en[5])
        begin
            d6_reg     <= 33'(lnp5_c) - 33'(cfg.log_scaling);
            delta6_reg <= delta5_reg;
            e6_reg     <= e5_reg;
            l6_reg     <= l5_reg;
        end
        if (en[6])
        begin
            pr7_reg    <= 59'($signed({1'b0, e6_reg})) * 59'(d6_reg);
            delta7_reg <= delta6_reg;
            l7_reg     <= l6_reg;
        end
        if (en[7])
        begin
            rsp_reg.delta     <= $signed(delta7_reg);
            rsp_reg.loss_term <= loss_c;
            rsp_reg.last_out  <= l7_reg;
        end
    end

    assign rsp_valid = v_reg[NS-1];
    assign rsp_data  = rsp_reg;

endmodule

### rtl/ce_checker.sv
// ce_checker: port-level assertions for cross_entropy_loss_gradient, with bind.
// depends on ce_pkg.
module ce_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [3:0]    paddr,
    input logic          pready,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input ce_pkg::rsp_t  rsp_data
);

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    // scale update blocks requests the next cycle
    a_derive_block: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[3:2] == ce_pkg::REG_DELTA_SCALE ||
                                      paddr[3:2] == ce_pkg::REG_OUTPUT_SCALING)
        |=> !req_ready)
        else $error("request taken during scale update");

    // apb never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // no result is valid while coming out of reset
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !rsp_valid)
        else $error("result right after reset");

endmodule

bind cross_entropy_loss_gradient ce_checker u_ce_checker (.*);
